/* src/drld_pkg.sv */
// ----------------------------------------------------------------------------
// drld_pkg - shared constants and helpers for the data run list decoder
// Field widths, header nibble layout and the byte-lane merge used to build
// little-endian length and offset fields.
// ----------------------------------------------------------------------------
package drld_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;      // bytes kept per field, 1..8
    localparam int unsigned ACC_BYTES       = 8;      // accumulators are 64 bits
    localparam int unsigned ACC_W           = 8 * ACC_BYTES;
    localparam int unsigned CNT_W           = 4;      // nibble-wide byte counts
    localparam int unsigned SHIFT_W         = 5;      // cluster_size_log2 width
    localparam int unsigned IN_DATA_W       = 8;
    localparam int unsigned OUT_DATA_W      = 4 * ACC_W;

    localparam logic [SHIFT_W-1:0] CLUSTER_LOG2_RESET = SHIFT_W'(12);

    // Drop byte b into lane idx of a little-endian accumulator. Lanes past
    // MAX_FIELD_BYTES are never written. With sext set, every lane above idx
    // takes the sign of b, so the last kept byte sets the sign of the field.
    function automatic logic [ACC_W-1:0] merge_byte(
        input logic [ACC_W-1:0] acc,
        input logic [CNT_W-1:0] idx,
        input logic [7:0]       b,
        input logic             sext
    );
        logic [ACC_W-1:0] res;
        res = acc;
        if (idx < CNT_W'(MAX_FIELD_BYTES)) begin
            for (int j = 0; j < ACC_BYTES; j++) begin
                if (CNT_W'(j) == idx) begin
                    res[8*j +: 8] = b;
                end else if (sext && (CNT_W'(j) > idx)) begin
                    res[8*j +: 8] = {8{b[7]}};
                end
            end
        end
        return res;
    endfunction

endpackage

/* src/data_run_list_decoder.sv */
// ----------------------------------------------------------------------------
// data_run_list_decoder - extent (data run) list decoder
// Parses header / length / offset bytes of a run list one word at a time and
// emits one word per completed run, or one on the terminating header.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input word passes through the input register, then is
//   decoded into the result register; a blocked output can hold it in between.
// Throughput: one input word per cycle unless a result waits on the output;
//   the byte's lane merge, barrel shift and 64-bit add form one decode stage.
// Reset (aresetn low, synchronous): pipeline empties, decoder expects a
//   header, running sums clear, cluster_size_log2 returns to 12.
module data_run_list_decoder
    import drld_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration: cluster_size_log2
    input  logic                  cfg_wr_en,
    input  logic [SHIFT_W-1:0]    cfg_wr_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] list_byte
    input  logic                  s_axis_tuser,   // [0] list_start

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [63:0] run_byte_offset, [127:64] run_length_bytes,
    // [191:128] first_position, [255:192] last_position
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser    // [0] end_of_list
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET,
        PH_DONE
    } phase_t;

    // ---------------- configuration ----------------
    logic [SHIFT_W-1:0] cluster_log2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_log2_reg <= CLUSTER_LOG2_RESET;
        end else if (cfg_wr_en) begin
            cluster_log2_reg <= cfg_wr_data;
        end
    end

    // ---------------- input register ----------------
    logic                 in_vld_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_start_reg;
    logic                 dec_fire;      // decode stage consumes the input word
    logic                 in_take;

    assign s_axis_tready = !in_vld_reg || dec_fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_take) begin
            in_vld_reg <= 1'b1;
        end else if (dec_fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // ---------------- decode state ----------------
    phase_t             phase_reg,     phase_next;
    logic [CNT_W-1:0]   len_tot_reg,   len_tot_next;
    logic [CNT_W-1:0]   off_tot_reg,   off_tot_next;
    logic [CNT_W-1:0]   idx_reg,       idx_next;
    logic [ACC_W-1:0]   len_acc_reg,   len_acc_next;
    logic [ACC_W-1:0]   dlt_acc_reg,   dlt_acc_next;
    logic [ACC_W-1:0]   run_off_reg,   run_off_next;
    logic [ACC_W-1:0]   nfp_reg,       nfp_next;

    // result of this word
    logic               res_vld;
    logic               res_eol;
    logic [ACC_W-1:0]   res_off, res_len, res_first, res_last;

    // output register
    logic               m_vld_reg;
    logic               out_free;

    assign out_free = !m_vld_reg || m_axis_tready;
    // A word that yields no result never waits on the output side.
    assign dec_fire = in_vld_reg && (!res_vld || out_free);

    // Decode of one byte. list_start clears the sums and forces a header.
    always_comb begin
        phase_t           ph;
        logic [ACC_W-1:0] off_base;
        logic [ACC_W-1:0] first_base;
        logic [CNT_W-1:0] idx_inc;
        logic [ACC_W-1:0] dlt_new;
        logic [ACC_W-1:0] len_sh;

        ph         = in_start_reg ? PH_HEADER : phase_reg;
        off_base   = in_start_reg ? '0 : run_off_reg;
        first_base = in_start_reg ? '0 : nfp_reg;
        idx_inc    = idx_reg + CNT_W'(1);
        dlt_new    = merge_byte(dlt_acc_reg, idx_reg, in_byte_reg, 1'b1);
        len_sh     = len_acc_reg << cluster_log2_reg;

        phase_next   = ph;
        len_tot_next = len_tot_reg;
        off_tot_next = off_tot_reg;
        idx_next     = idx_reg;
        len_acc_next = len_acc_reg;
        dlt_acc_next = dlt_acc_reg;
        run_off_next = off_base;
        nfp_next     = first_base;

        res_vld   = 1'b0;
        res_eol   = 1'b0;
        res_off   = '0;
        res_len   = '0;
        res_first = '0;
        res_last  = '0;

        case (ph)
            PH_HEADER: begin
                len_tot_next = in_byte_reg[3:0];
                off_tot_next = in_byte_reg[7:4];
                idx_next     = '0;
                len_acc_next = '0;
                dlt_acc_next = '0;
                if ((in_byte_reg[3:0] == '0) || (in_byte_reg[7:4] == '0)) begin
                    // terminator: length or offset size nibble is zero
                    phase_next = PH_DONE;
                    res_vld    = 1'b1;
                    res_eol    = 1'b1;
                end else begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                len_acc_next = merge_byte(len_acc_reg, idx_reg, in_byte_reg, 1'b0);
                if (idx_inc >= len_tot_reg) begin
                    idx_next   = '0;
                    phase_next = PH_OFFSET;
                end else begin
                    idx_next = idx_inc;
                end
            end
            PH_OFFSET: begin
                dlt_acc_next = dlt_new;
                if (idx_inc < off_tot_reg) begin
                    idx_next = idx_inc;
                end else begin
                    // run complete
                    idx_next     = '0;
                    phase_next   = PH_HEADER;
                    run_off_next = off_base + (dlt_new << cluster_log2_reg);
                    nfp_next     = first_base + len_sh + ACC_W'(1);
                    res_vld      = 1'b1;
                    res_off      = run_off_next;
                    res_len      = len_sh;
                    res_first    = first_base;
                    res_last     = first_base + len_sh;
                end
            end
            default: begin
                // after the terminator: swallow bytes until list_start
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            len_tot_reg <= '0;
            off_tot_reg <= '0;
            idx_reg     <= '0;
            len_acc_reg <= '0;
            dlt_acc_reg <= '0;
            run_off_reg <= '0;
            nfp_reg     <= '0;
        end else if (dec_fire) begin
            phase_reg   <= phase_next;
            len_tot_reg <= len_tot_next;
            off_tot_reg <= off_tot_next;
            idx_reg     <= idx_next;
            len_acc_reg <= len_acc_next;
            dlt_acc_reg <= dlt_acc_next;
            run_off_reg <= run_off_next;
            nfp_reg     <= nfp_next;
        end
    end

    // ---------------- result register ----------------
    logic              out_load;
    logic              m_eol_reg;
    logic [ACC_W-1:0]  m_off_reg, m_len_reg, m_first_reg, m_last_reg;

    assign out_load = dec_fire && res_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (out_load) begin
            m_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_eol_reg   <= res_eol;
            m_off_reg   <= res_off;
            m_len_reg   <= res_len;
            m_first_reg <= res_first;
            m_last_reg  <= res_last;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tuser  = m_eol_reg;
    assign m_axis_tdata  = {m_last_reg, m_first_reg, m_len_reg, m_off_reg};

    // ---------------- assertions ----------------
    a_eol_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("end-of-list word carries nonzero fields");

    a_last_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_last_reg == m_first_reg + m_len_reg))
        else $error("last_position differs from first plus length");

    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_vld_reg && res_vld && m_vld_reg))
        else $error("input stalled without a blocked result");

    a_eol_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_eol) |=> (phase_reg == PH_DONE))
        else $error("decoder not parked after terminator");

endmodule
